// ----- hdl/clce_pkg.sv -----
`timescale 1ns / 1ps

package clce_pkg;

  localparam int ACTION_BITS = 3;
  localparam int STATUS_BITS = 2;
  localparam int DATA_BITS   = 32;
  localparam int COUNT_BITS  = 7;

  localparam logic [ACTION_BITS-1:0] ACT_INS_AFTER  = 3'd0;
  localparam logic [ACTION_BITS-1:0] ACT_INS_BEFORE = 3'd1;
  localparam logic [ACTION_BITS-1:0] ACT_DELETE     = 3'd2;
  localparam logic [ACTION_BITS-1:0] ACT_MOVE_NEXT  = 3'd3;
  localparam logic [ACTION_BITS-1:0] ACT_MOVE_PREV  = 3'd4;

  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LINK = 4'b0010,
    S_FIX  = 4'b0100,
    S_DONE = 4'b1000
  } seq_state_t;

  typedef struct packed {
    logic pop;
    logic push;
  } free_ctl_t;

endpackage

// ----- hdl/clce_ifs.sv -----
`timescale 1ns / 1ps

interface clce_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [clce_pkg::ACTION_BITS-1:0]     action;
  logic signed [clce_pkg::DATA_BITS-1:0] value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface clce_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic [clce_pkg::STATUS_BITS-1:0]      status;
  logic signed [clce_pkg::DATA_BITS-1:0] cursor_value;
  logic                                  nonempty;
  logic [clce_pkg::COUNT_BITS-1:0]       node_count;

  modport source (output valid, status, cursor_value, nonempty, node_count, input ready);
  modport sink   (input valid, status, cursor_value, nonempty, node_count, output ready);
endinterface

// ----- hdl/clce_ram.sv -----
`timescale 1ns / 1ps

module clce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- hdl/clce_free_list.sv -----
`timescale 1ns / 1ps

module clce_free_list #(
  parameter int NODES = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  clce_pkg::free_ctl_t      ctl,
  input  logic [$clog2(NODES)-1:0] push_node,
  output logic [$clog2(NODES)-1:0] node,
  output logic                     empty
);

  localparam int IW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] mark;
  logic [CW-1:0] top;
  logic [CW-1:0] fresh;
  logic [IW-1:0] rdata;
  logic [IW-1:0] addr;

  // Slots below the low-water mark were never written; node is then derived from count.
  assign top   = count - 1'b1;
  assign fresh = CW'(NODES) - count;
  assign addr  = ctl.push ? count[IW-1:0] : top[IW-1:0];
  assign node  = (count == mark) ? fresh[IW-1:0] : rdata;
  assign empty = (count == '0);

  clce_ram #(.WIDTH(IW), .DEPTH(NODES)) u_stack (
    .clk   (clk),
    .we    (ctl.push),
    .addr  (addr),
    .wdata (push_node),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CW'(NODES);
      mark  <= CW'(NODES);
    end else if (ctl.pop) begin
      count <= top;
      if (count == mark) begin
        mark <= top;
      end
    end else if (ctl.push) begin
      count <= count + 1'b1;
    end
  end

endmodule

// ----- hdl/cyclic_list_cursor_engine.sv -----
`timescale 1ns / 1ps
// Channel | Dir | Payload                                        | Handshake
// req     | in  | action[2:0], value[31:0]                       | valid/ready
// rsp     | out | status[1:0], cursor_value[31:0], nonempty,     | valid/ready
//         |     | node_count[6:0]                                |
// Insert, delete and move pass through the link and fix states: the link RAMs are
// single port, and an insert writes the next-link RAM twice after reading it.
// Dropped inserts, operations on an empty ring and unused codes skip to S_DONE.
// Reset (rst, synchronous) empties the ring; the free list needs no sweep.
// A stalled response holds the engine in its final state until taken; a new
// request is accepted while the previous response still waits.

module cyclic_list_cursor_engine #(
  parameter int NODES      = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  clce_req_if.sink       req,
  clce_rsp_if.source     rsp
);

  localparam int IW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);
  localparam int XW = (VALUE_BITS > clce_pkg::DATA_BITS) ? VALUE_BITS : clce_pkg::DATA_BITS;

  clce_pkg::seq_state_t state;
  clce_pkg::free_ctl_t  free_ctl;

  logic [clce_pkg::ACTION_BITS-1:0]  act;
  logic [clce_pkg::DATA_BITS-1:0]    val;
  logic [clce_pkg::STATUS_BITS-1:0]  status;
  logic [CW-1:0]                     ring_count;
  logic [IW-1:0]                     cursor;
  logic [VALUE_BITS-1:0]             cur_val;
  logic [VALUE_BITS-1:0]             cur_val_next;
  logic [IW-1:0]                     nn;
  logic [IW-1:0]                     nb;
  logic                              link2;
  logic                              after;
  logic                              rd_val;

  logic                  next_we, prev_we, val_we;
  logic [IW-1:0]         next_addr, prev_addr, val_addr;
  logic [IW-1:0]         next_wd, prev_wd;
  logic [IW-1:0]         nx, pv, fnode;
  logic [VALUE_BITS-1:0] val_rd;
  logic [VALUE_BITS-1:0] vstore;
  logic [XW-1:0]         vz;
  logic [XW-1:0]         cv_x;
  logic [VALUE_BITS-1:0] cv_src;
  logic                  free_empty;
  logic                  accept;
  logic                  out_free;
  logic                  load_out;

  assign vz     = XW'($unsigned(val));
  assign vstore = vz[VALUE_BITS-1:0];

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == clce_pkg::S_IDLE);
  assign out_free = !rsp.valid || rsp.ready;
  assign load_out = out_free && (state == clce_pkg::S_FIX || state == clce_pkg::S_DONE);

  assign cur_val_next = rd_val ? val_rd : cur_val;
  assign cv_src       = (state == clce_pkg::S_FIX) ? cur_val_next : cur_val;
  assign cv_x         = XW'($signed(cv_src));

  clce_ram #(.WIDTH(IW), .DEPTH(NODES)) u_next (
    .clk (clk), .we (next_we), .addr (next_addr), .wdata (next_wd), .rdata (nx)
  );

  clce_ram #(.WIDTH(IW), .DEPTH(NODES)) u_prev (
    .clk (clk), .we (prev_we), .addr (prev_addr), .wdata (prev_wd), .rdata (pv)
  );

  clce_ram #(.WIDTH(VALUE_BITS), .DEPTH(NODES)) u_value (
    .clk (clk), .we (val_we), .addr (val_addr), .wdata (vstore), .rdata (val_rd)
  );

  clce_free_list #(.NODES(NODES)) u_free (
    .clk       (clk),
    .rst       (rst),
    .ctl       (free_ctl),
    .push_node (cursor),
    .node      (fnode),
    .empty     (free_empty)
  );

  always_comb begin
    next_we   = 1'b0;
    next_addr = cursor;
    next_wd   = fnode;
    prev_we   = 1'b0;
    prev_addr = cursor;
    prev_wd   = fnode;
    val_we    = 1'b0;
    val_addr  = fnode;
    free_ctl  = '0;
    case (state)
      clce_pkg::S_LINK: begin
        case (act)
          clce_pkg::ACT_INS_AFTER, clce_pkg::ACT_INS_BEFORE: begin
            free_ctl.pop = 1'b1;
            val_we       = 1'b1;
            next_we      = 1'b1;
            prev_we      = 1'b1;
            if (ring_count == '0) begin
              next_addr = fnode;
              prev_addr = fnode;
            end else if (act == clce_pkg::ACT_INS_AFTER) begin
              prev_addr = nx;
            end else begin
              next_addr = pv;
            end
          end
          clce_pkg::ACT_DELETE: begin
            free_ctl.push = 1'b1;
            val_addr      = nx;
            if (ring_count != CW'(1)) begin
              next_we   = 1'b1;
              next_addr = pv;
              next_wd   = nx;
              prev_we   = 1'b1;
              prev_addr = nx;
              prev_wd   = pv;
            end
          end
          clce_pkg::ACT_MOVE_NEXT: val_addr = nx;
          clce_pkg::ACT_MOVE_PREV: val_addr = pv;
          default: ;
        endcase
      end
      clce_pkg::S_FIX: begin
        // finish splicing the new node in
        if (link2) begin
          next_we   = 1'b1;
          next_addr = nn;
          next_wd   = after ? nb : cursor;
          prev_we   = 1'b1;
          prev_addr = nn;
          prev_wd   = after ? cursor : nb;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= clce_pkg::S_IDLE;
      ring_count <= '0;
      cursor     <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      if (load_out) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        clce_pkg::S_IDLE: begin
          if (accept) begin
            case (req.action)
              clce_pkg::ACT_INS_AFTER, clce_pkg::ACT_INS_BEFORE:
                state <= free_empty ? clce_pkg::S_DONE : clce_pkg::S_LINK;
              clce_pkg::ACT_DELETE, clce_pkg::ACT_MOVE_NEXT, clce_pkg::ACT_MOVE_PREV:
                state <= (ring_count == '0) ? clce_pkg::S_DONE : clce_pkg::S_LINK;
              default:
                state <= clce_pkg::S_DONE;
            endcase
          end
        end
        clce_pkg::S_LINK: begin
          state <= clce_pkg::S_FIX;
          case (act)
            clce_pkg::ACT_INS_AFTER, clce_pkg::ACT_INS_BEFORE: begin
              ring_count <= ring_count + 1'b1;
              if (ring_count == '0) begin
                cursor <= fnode;
              end
            end
            clce_pkg::ACT_DELETE: begin
              ring_count <= ring_count - 1'b1;
              cursor     <= (ring_count != CW'(1)) ? nx : '0;
            end
            clce_pkg::ACT_MOVE_NEXT: cursor <= nx;
            clce_pkg::ACT_MOVE_PREV: cursor <= pv;
            default: ;
          endcase
        end
        clce_pkg::S_FIX: begin
          state <= load_out ? clce_pkg::S_IDLE : clce_pkg::S_DONE;
        end
        clce_pkg::S_DONE: begin
          if (load_out) begin
            state <= clce_pkg::S_IDLE;
          end
        end
        default: state <= clce_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      clce_pkg::S_IDLE: begin
        if (accept) begin
          act    <= req.action;
          val    <= req.value;
          link2  <= 1'b0;
          rd_val <= 1'b0;
          status <= clce_pkg::ST_OK;
          case (req.action)
            clce_pkg::ACT_INS_AFTER, clce_pkg::ACT_INS_BEFORE: begin
              if (free_empty) begin
                status <= clce_pkg::ST_FULL;
              end
            end
            clce_pkg::ACT_DELETE, clce_pkg::ACT_MOVE_NEXT, clce_pkg::ACT_MOVE_PREV: begin
              if (ring_count == '0) begin
                status <= clce_pkg::ST_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      clce_pkg::S_LINK: begin
        case (act)
          clce_pkg::ACT_INS_AFTER, clce_pkg::ACT_INS_BEFORE: begin
            after <= (act == clce_pkg::ACT_INS_AFTER);
            nn    <= fnode;
            nb    <= (act == clce_pkg::ACT_INS_AFTER) ? nx : pv;
            if (ring_count == '0) begin
              cur_val <= vstore;
            end else begin
              link2 <= 1'b1;
            end
          end
          clce_pkg::ACT_DELETE: rd_val <= (ring_count != CW'(1));
          clce_pkg::ACT_MOVE_NEXT, clce_pkg::ACT_MOVE_PREV: rd_val <= 1'b1;
          default: ;
        endcase
      end
      clce_pkg::S_FIX: cur_val <= cur_val_next;
      default: ;
    endcase
    if (load_out) begin
      rsp.status       <= status;
      rsp.cursor_value <= (ring_count != '0) ? cv_x[clce_pkg::DATA_BITS-1:0] : '0;
      rsp.nonempty     <= (ring_count != '0);
      rsp.node_count   <= clce_pkg::COUNT_BITS'(ring_count);
    end
  end

endmodule

// ----- tb/clce_ring_checker.sv -----
`timescale 1ns / 1ps

module clce_ring_checker
  import clce_pkg::*;
#(
  parameter int NODES = 64
) (
  input  logic       clk,
  input  logic       rst,
  clce_req_if        req,
  clce_rsp_if        rsp,
  output int         fail_count,
  output int         pending,
  output int         checked,
  output int         full_drops,
  output int         empty_ops,
  output int         peak_nodes
);

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [DATA_BITS-1:0]   cursor_value;
    logic                   nonempty;
    logic [COUNT_BITS-1:0]  node_count;
  } cursor_report_t;

  // Shadow copy of the ring held in the node pool
  logic [DATA_BITS-1:0]  node_val [NODES];
  logic [5:0]            fwd_link [NODES];
  logic [5:0]            back_link[NODES];
  logic [5:0]            free_stk [NODES];
  logic [COUNT_BITS-1:0] free_cnt;
  logic [COUNT_BITS-1:0] ring_cnt;
  logic [5:0]            cur;

  cursor_report_t awaited_reports[$];

  task automatic clear_ring();
    for (int i = 0; i < NODES; i++) begin
      free_stk[i] = 6'(NODES - 1 - i);
    end
    free_cnt = COUNT_BITS'(NODES);
    ring_cnt = '0;
    cur      = '0;
  endtask

  task automatic step_ring(input logic [ACTION_BITS-1:0] act,
                           input logic [DATA_BITS-1:0] val,
                           output cursor_report_t rpt);
    logic [5:0] n;
    logic [5:0] nb;
    logic [5:0] nx;
    logic [5:0] pv;
    rpt.status = ST_OK;
    case (act)
      ACT_INS_AFTER, ACT_INS_BEFORE: begin
        if (free_cnt == 0 || ring_cnt >= NODES) begin
          rpt.status = ST_FULL;
        end else begin
          free_cnt = free_cnt - 1'b1;
          n = free_stk[free_cnt[5:0]];
          node_val[n] = val;
          if (ring_cnt == 0) begin
            fwd_link[n]  = n;
            back_link[n] = n;
            cur = n;
          end else if (act == ACT_INS_AFTER) begin
            nb = fwd_link[cur];
            back_link[n]  = cur;
            fwd_link[n]   = nb;
            back_link[nb] = n;
            fwd_link[cur] = n;
          end else begin
            nb = back_link[cur];
            fwd_link[n]    = cur;
            back_link[n]   = nb;
            fwd_link[nb]   = n;
            back_link[cur] = n;
          end
          ring_cnt = ring_cnt + 1'b1;
        end
      end
      ACT_DELETE, ACT_MOVE_NEXT, ACT_MOVE_PREV: begin
        if (ring_cnt == 0) begin
          rpt.status = ST_EMPTY;
        end else if (act == ACT_DELETE) begin
          n  = cur;
          nx = fwd_link[n];
          pv = back_link[n];
          if (ring_cnt > 1) begin
            fwd_link[pv]  = nx;
            back_link[nx] = pv;
            cur = nx;
          end else begin
            cur = '0;
          end
          ring_cnt = ring_cnt - 1'b1;
          if (free_cnt < NODES) begin
            free_stk[free_cnt[5:0]] = n;
            free_cnt = free_cnt + 1'b1;
          end
        end else if (act == ACT_MOVE_NEXT) begin
          cur = fwd_link[cur];
        end else begin
          cur = back_link[cur];
        end
      end
      default: ;
    endcase
    rpt.cursor_value = (ring_cnt != 0) ? node_val[cur] : '0;
    rpt.nonempty     = (ring_cnt != 0);
    rpt.node_count   = ring_cnt;
  endtask

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    cursor_report_t rpt;
    cursor_report_t want;
    if (rst) begin
      clear_ring();
      awaited_reports.delete();
    end else begin
      // A response never leaves in the cycle its request enters, so push first
      if (req.valid && req.ready) begin
        step_ring(req.action, req.value, rpt);
        if (rpt.status == ST_FULL) full_drops++;
        if (rpt.status == ST_EMPTY) empty_ops++;
        if (int'(ring_cnt) > peak_nodes) peak_nodes = ring_cnt;
        awaited_reports.push_back(rpt);
      end
      if (rsp.valid && rsp.ready) begin
        if (awaited_reports.size() == 0) begin
          fail_count++;
          $display("%0t: response with no request outstanding: expected none, actual %h %h %b %0d",
                   $time, rsp.status, rsp.cursor_value, rsp.nonempty, rsp.node_count);
        end else begin
          want = awaited_reports.pop_front();
          checked++;
          compare_field("status", 32'(want.status), 32'(rsp.status));
          compare_field("cursor_value", want.cursor_value, rsp.cursor_value);
          compare_field("nonempty", 32'(want.nonempty), 32'(rsp.nonempty));
          compare_field("node_count", 32'(want.node_count), 32'(rsp.node_count));
        end
      end
    end
    pending = awaited_reports.size();
  end

endmodule

// ----- tb/cyclic_list_cursor_engine_tb.sv -----
`timescale 1ns / 1ps

module cyclic_list_cursor_engine_tb;
  import clce_pkg::*;

  localparam int NODES       = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 560;
  localparam int TAIL_CYCLES = 20;

  localparam logic [ACTION_BITS-1:0] ACT_SPARE_LO = ACT_MOVE_PREV + 1'b1;
  localparam logic [ACTION_BITS-1:0] ACT_SPARE_HI = '1;

  typedef enum int {MOOD_GROW, MOOD_SHRINK, MOOD_CHURN} mood_t;

  logic clk;
  logic rst;
  int   snd_idle_pct;
  int   rcv_stall_pct;
  int   sent;
  int   quiet_cycles;

  int fail_count;
  int pending;
  int checked;
  int full_drops;
  int empty_ops;
  int peak_nodes;

  clce_req_if req_ch ();
  clce_rsp_if rsp_ch ();

  cyclic_list_cursor_engine #(
    .NODES      (NODES),
    .VALUE_BITS (DATA_BITS)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  clce_ring_checker #(
    .NODES (NODES)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .full_drops (full_drops),
    .empty_ops  (empty_ops),
    .peak_nodes (peak_nodes)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: stall at random, decided once per falling edge
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready <= !rst && ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("** cyclic_list_cursor_engine: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic [ACTION_BITS-1:0] act,
                              input logic [DATA_BITS-1:0] val);
    while ($urandom_range(99) < snd_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.value  <= val;
    do begin
      @(posedge clk);
    end while (!req_ch.ready);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic [DATA_BITS-1:0] pick_value();
    case ($urandom_range(15))
      0:       return {1'b1, {(DATA_BITS-1){1'b0}}};
      1:       return {1'b0, {(DATA_BITS-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ACTION_BITS-1:0] pick_action(input mood_t mood);
    int r;
    int ins_pct;
    int del_pct;
    r = $urandom_range(99);
    case (mood)
      MOOD_GROW:   begin ins_pct = 75; del_pct = 10; end
      MOOD_SHRINK: begin ins_pct = 25; del_pct = 50; end
      default:     begin ins_pct = 35; del_pct = 25; end
    endcase
    if (r < 3) return ACTION_BITS'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    r = $urandom_range(99);
    if (r < ins_pct) return $urandom_range(1) ? ACT_INS_AFTER : ACT_INS_BEFORE;
    if (r < ins_pct + del_pct) return ACT_DELETE;
    return $urandom_range(1) ? ACT_MOVE_NEXT : ACT_MOVE_PREV;
  endfunction

  // Swing the ring between empty and a full pool by drifting the mix in bursts
  task automatic random_requests(input int count);
    mood_t mood;
    int    burst;
    mood  = MOOD_CHURN;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        mood  = mood_t'($urandom_range(2));
        burst = $urandom_range(20, 120);
      end
      burst--;
      send_request(pick_action(mood), pick_value());
    end
  endtask

  initial begin
    rst           = 1'b1;
    req_ch.valid  = 1'b0;
    req_ch.action = ACT_INS_AFTER;
    req_ch.value  = '0;
    snd_idle_pct  = 31;
    rcv_stall_pct = 78;
    sent          = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty ring, spare codes, extremes, first insert, delete of the last node
    send_request(ACT_DELETE, $urandom);
    send_request(ACT_MOVE_NEXT, $urandom);
    send_request(ACT_MOVE_PREV, $urandom);
    send_request(ACT_SPARE_LO, $urandom);
    send_request(ACT_SPARE_LO + 1'b1, $urandom);
    send_request(ACT_SPARE_HI, $urandom);
    send_request(ACT_INS_AFTER, 32'h8000_0000);
    send_request(ACT_INS_AFTER, 32'h7fff_ffff);
    send_request(ACT_INS_BEFORE, 32'hffff_ffff);
    send_request(ACT_INS_BEFORE, 32'h0000_0000);
    send_request(ACT_MOVE_NEXT, $urandom);
    send_request(ACT_MOVE_NEXT, $urandom);
    send_request(ACT_MOVE_PREV, $urandom);
    send_request(ACT_MOVE_PREV, $urandom);
    send_request(ACT_SPARE_HI, $urandom);
    send_request(ACT_DELETE, $urandom);
    send_request(ACT_DELETE, $urandom);
    send_request(ACT_DELETE, $urandom);
    send_request(ACT_DELETE, $urandom);
    send_request(ACT_DELETE, $urandom);
    send_request(ACT_INS_BEFORE, 32'h5555_5555);
    send_request(ACT_INS_AFTER, 32'haaaa_aaaa);
    send_request(ACT_MOVE_PREV, $urandom);
    send_request(ACT_DELETE, $urandom);

    random_requests(PHASE_ITEMS);
    snd_idle_pct  = 78;
    rcv_stall_pct = 31;
    random_requests(PHASE_ITEMS);
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    random_requests(PHASE_ITEMS);
    req_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d requests over three sender/receiver stall mixes; %0d responses checked.",
             sent, checked);
    $display("Ring peaked at %0d nodes; %0d inserts hit a full pool, %0d ops hit an empty ring.",
             peak_nodes, full_drops, empty_ops);
    if (fail_count == 0) begin
      $display("** cyclic_list_cursor_engine: PASSED **");
    end else begin
      $display("** cyclic_list_cursor_engine: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/clce_pkg.sv
hdl/clce_ifs.sv
hdl/clce_ram.sv
hdl/clce_free_list.sv
hdl/cyclic_list_cursor_engine.sv
tb/clce_ring_checker.sv
tb/cyclic_list_cursor_engine_tb.sv
